@@ hw/rtl/sfscp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sum-16 frame parser package
// Shared constants, configuration register codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfscp_pkg;

    // Buffer depth in data words (range 1 to 32)
    localparam int DATA_WORDS   = 19;
    localparam int IDX_W        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int WORD_INDEX_W = 5;
    localparam int CFG_IDX_W    = 2;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'h2D;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h23;
    localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd44;

    // Shortest legal frame, and bytes of header, length and checksum
    localparam logic [7:0] MIN_FRAME_LEN  = 8'd8;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic sum_load;    // restart the sum with the current byte
        logic sum_add;     // add the current byte to the sum
        logic low_load;    // hold the current byte as a low byte
        logic len_take;    // latch the frame length and word count
        logic data_take;   // sum, hold and store one data byte
        logic emit_clear;  // restart the emit index
        logic emit_read;   // read the buffered word at the emit index
        logic emit_next;   // advance the emit index
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic len_ok;
        logic data_last;
        logic sum_ok;
        logic emit_last;
    } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/sfscp_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfscp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 19,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/sfscp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sum-16 frame parser controller
// Parse phase sequencing and word emission handshake.
// ----------------------------------------------------------------------------
module sfscp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sfscp_pkg::dp_status_t status,
    output sfscp_pkg::dp_cmd_t    cmd
);
    import sfscp_pkg::*;

    typedef enum logic [8:0] {
        ST_HUNT1 = 9'b000000001,
        ST_HUNT2 = 9'b000000010,
        ST_LENLO = 9'b000000100,
        ST_LENHI = 9'b000001000,
        ST_DATA  = 9'b000010000,
        ST_CSLO  = 9'b000100000,
        ST_CSHI  = 9'b001000000,
        ST_LOAD  = 9'b010000000,
        ST_SHOW  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready  = (state_reg != ST_LOAD) && (state_reg != ST_SHOW);
    assign out_valid = (state_reg == ST_SHOW);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT1:
            begin
                if (in_fire && status.hdr1_hit)
                begin
                    cmd.sum_load = 1'b1;
                    state_next   = ST_HUNT2;
                end
            end
            ST_HUNT2:
            begin
                if (in_fire)
                begin
                    if (status.hdr2_hit)
                    begin
                        cmd.sum_add = 1'b1;
                        state_next  = ST_LENLO;
                    end
                    else if (status.hdr1_hit)
                    begin
                        cmd.sum_load = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_LENLO:
            begin
                if (in_fire)
                begin
                    cmd.low_load = 1'b1;
                    cmd.sum_add  = 1'b1;
                    state_next   = ST_LENHI;
                end
            end
            ST_LENHI:
            begin
                if (in_fire)
                begin
                    if (status.len_ok)
                    begin
                        cmd.len_take = 1'b1;
                        state_next   = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.data_take = 1'b1;
                    if (status.data_last)
                    begin
                        state_next = ST_CSLO;
                    end
                end
            end
            ST_CSLO:
            begin
                if (in_fire)
                begin
                    cmd.low_load = 1'b1;
                    state_next   = ST_CSHI;
                end
            end
            ST_CSHI:
            begin
                if (in_fire)
                begin
                    if (status.sum_ok)
                    begin
                        cmd.emit_clear = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    if (status.emit_last)
                    begin
                        state_next = ST_HUNT1;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sfscp_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sum-16 frame parser datapath
// Configuration registers, running sum, length checks, word buffer and the
// emit index.
// ----------------------------------------------------------------------------
module sfscp_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic [sfscp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [7:0]                              cfg_data,
    input  logic [7:0]                              rx_byte,
    input  sfscp_pkg::dp_cmd_t                      cmd,
    output sfscp_pkg::dp_status_t                   status,
    output logic [sfscp_pkg::WORD_INDEX_W-1:0]      word_index,
    output logic [15:0]                             word_value,
    output logic                                    last_word
);
    import sfscp_pkg::*;

    logic [7:0]       hdr1_reg;
    logic [7:0]       hdr2_reg;
    logic [7:0]       max_len_reg;
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [7:0]       low_reg;
    logic [7:0]       frame_len_reg;
    logic [7:0]       pos_reg;
    logic [IDX_W-1:0] emit_idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic [IDX_W-1:0] last_idx_next;

    logic [7:0]       data_len;
    logic [7:0]       pos_inc;
    logic [6:0]       half_len;
    logic [6:0]       word_slot;
    logic             store_we;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg    <= HEADER_FIRST_RST;
            hdr2_reg    <= HEADER_SECOND_RST;
            max_len_reg <= MAX_FRAME_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  hdr1_reg    <= cfg_data;
                CFG_HEADER_SECOND: hdr2_reg    <= cfg_data;
                CFG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign data_len  = frame_len_reg - FRAME_OVERHEAD;
    assign pos_inc   = pos_reg + 8'd1;
    assign half_len  = 7'((low_reg - FRAME_OVERHEAD) >> 1);
    assign word_slot = pos_reg[7:1];
    assign store_we  = cmd.data_take && pos_reg[0] && (word_slot < 7'(DATA_WORDS));

    always_comb
    begin
        if (half_len > 7'(DATA_WORDS))
        begin
            last_idx_next = IDX_W'(DATA_WORDS - 1);
        end
        else
        begin
            last_idx_next = IDX_W'(half_len - 7'd1);
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_load)
        begin
            sum_next = {8'd0, rx_byte};
        end
        else if (cmd.sum_add || cmd.data_take)
        begin
            sum_next = sum_reg + {8'd0, rx_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            low_reg       <= '0;
            frame_len_reg <= '0;
            pos_reg       <= '0;
            emit_idx_reg  <= '0;
            last_idx_reg  <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.low_load || (cmd.data_take && !pos_reg[0]))
            begin
                low_reg <= rx_byte;
            end
            if (cmd.len_take)
            begin
                frame_len_reg <= low_reg;
                pos_reg       <= '0;
                last_idx_reg  <= last_idx_next;
            end
            else if (cmd.data_take)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.emit_clear)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
        end
    end

    sfscp_ram #(
        .WIDTH (16),
        .DEPTH (DATA_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (IDX_W'(word_slot)),
        .wdata ({rx_byte, low_reg}),
        .re    (cmd.emit_read),
        .raddr (emit_idx_reg),
        .rdata (word_value)
    );

    assign status.hdr1_hit  = (rx_byte == hdr1_reg);
    assign status.hdr2_hit  = (rx_byte == hdr2_reg);
    assign status.len_ok    = (rx_byte == 8'd0) && (low_reg >= MIN_FRAME_LEN)
                              && (low_reg <= max_len_reg);
    assign status.data_last = (pos_inc >= data_len);
    assign status.sum_ok    = ({rx_byte, low_reg} == sum_reg);
    assign status.emit_last = (emit_idx_reg == last_idx_reg);

    assign word_index = WORD_INDEX_W'(emit_idx_reg);
    assign last_word  = status.emit_last;

endmodule
`default_nettype wire

@@ hw/rtl/sensor_frame_sum_checksum_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sum-16 checksummed sensor frame parser
// Hunts for a two-byte header, checks a whole-frame length, buffers the
// little-endian data words and emits them when the sum-16 checksum matches.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Payload
//  -------  ---  --------------------  ---------------------------------------
//  cfg      in   cfg_valid/cfg_ready   cfg_index (2b), cfg_data (8b)
//  in       in   in_valid/in_ready     rx_byte (8b)
//  out      out  out_valid/out_ready   word_index (5b), word_value (16b),
//                                      last_word (1b)
//
//  One byte is taken per cycle while a frame is parsed; a byte never causes
//  a wait. After a good checksum each buffered word takes a read of the word
//  buffer, then the request on the output, and the input stays blocked until
//  the final word is accepted on the output.
//  Reset restores the header bytes and maximum length and returns to hunting.
//  The word buffer is not cleared: every word emitted is written in its frame.
//  Configuration writes are taken in every cycle.
//
module sensor_frame_sum_checksum_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfscp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfscp_pkg::WORD_INDEX_W-1:0]  word_index,
    output logic [15:0]                         word_value,
    output logic                                last_word
);
    import sfscp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    // Sequence the parse phases and the emit handshake
    sfscp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the sum, lengths and buffered words; drive the result payload
    sfscp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .status     (status),
        .word_index (word_index),
        .word_value (word_value),
        .last_word  (last_word)
    );

endmodule
`default_nettype wire

@@ hw/rtl/sfscp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sum-16 frame parser port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sfscp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [sfscp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [7:0]                          cfg_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [7:0]                          rx_byte,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [sfscp_pkg::WORD_INDEX_W-1:0]  word_index,
    input logic [15:0]                         word_value,
    input logic                                last_word
);
    import sfscp_pkg::*;

    // Input is held off while words are being emitted
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken during word emission");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_index)
            && $stable(word_value) && $stable(last_word))
        else $error("stalled result changed");

    // The final word ends the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid)
        else $error("result after final word");

    // Indexes stay within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_index < WORD_INDEX_W'(DATA_WORDS))
        else $error("word index beyond buffer");

    // Burst opens at word zero; antecedent is never true
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(in_ready) |-> word_index == '0)
        else $error("burst does not start at word zero");

endmodule

bind sensor_frame_sum_checksum_parser_core sfscp_checker u_sfscp_checker (.*);
`default_nettype wire
